// File: sv/tce_pkg.sv
`default_nettype none

package tce_pkg;

   // default screen geometry
   localparam int DefColumns = 80;
   localparam int DefRows    = 25;

   // fixed field widths
   localparam int CmdWidth    = 3;
   localparam int CharWidth   = 8;
   localparam int TargetWidth = 8;
   localparam int AttrWidth   = 8;
   localparam int CellWidth   = 16;
   localparam int RowOutWidth = 5;
   localparam int ColOutWidth = 7;
   localparam int PosOutWidth = 11;

   // depth of the queue between front and back
   localparam int QueueDepth = 2;

   // character and attribute constants
   localparam logic [CharWidth-1:0] CharNewline    = 8'd10;
   localparam logic [CharWidth-1:0] CharSpace      = 8'h20;
   localparam logic [AttrWidth-1:0] ResetAttribute = 8'h07;

   // command codes on the input channel
   localparam logic [CmdWidth-1:0] CmdPutChar   = 3'd0;
   localparam logic [CmdWidth-1:0] CmdBackspace = 3'd1;
   localparam logic [CmdWidth-1:0] CmdClear     = 3'd2;
   localparam logic [CmdWidth-1:0] CmdSetCursor = 3'd3;
   localparam logic [CmdWidth-1:0] CmdReadCell  = 3'd4;

   // classified operation handed from front to back
   typedef enum logic [2:0] {
      OpPutChar,
      OpNewline,
      OpBackspace,
      OpClear,
      OpSetCursor,
      OpReadCell,
      OpNop
   } op_type;

   // one queued word: operation, character and clamped targets
   typedef struct packed {
      op_type                 op;
      logic [CharWidth-1:0]   char_code;
      logic [TargetWidth-1:0] row;
      logic [TargetWidth-1:0] col;
   } entry_type;

endpackage

`default_nettype wire

// File: sv/text_console_engine.sv
`default_nettype none

// channel   direction  handshake           word
// req_      in         push / full         command, char_code, target_row, target_col
// rsp_      out        pop / empty         cursor_row, cursor_col, cursor_position,
//                                          cell_value
// csr_      in         wr_en, no wait      wr_data = attribute byte
//
// Put char, newline, backspace, set cursor and unused commands complete in the idle state;
// read cell also passes a read state (registered store read). Scroll sweeps the COLUMNS
// cells of one row and clear all ROWS * 2**clog2(COLUMNS) cells, one cell written per cycle.
// After reset the same sweep loads blank cells; req_full stays high while it runs. A two-word
// queue takes commands while the back end works; a word starts only once the previous result
// is popped or being popped, so a waiting result stalls it.

module text_console_engine #(
   parameter int COLUMNS = tce_pkg::DefColumns,
   parameter int ROWS    = tce_pkg::DefRows
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_push,
   output logic                                  req_full,
   input  wire logic [tce_pkg::CmdWidth-1:0]     req_command,
   input  wire logic [tce_pkg::CharWidth-1:0]    req_char_code,
   input  wire logic [tce_pkg::TargetWidth-1:0]  req_target_row,
   input  wire logic [tce_pkg::TargetWidth-1:0]  req_target_col,
   output logic                                  rsp_empty,
   input  wire logic                             rsp_pop,
   output logic [tce_pkg::RowOutWidth-1:0]       rsp_cursor_row,
   output logic [tce_pkg::ColOutWidth-1:0]       rsp_cursor_col,
   output logic [tce_pkg::PosOutWidth-1:0]       rsp_cursor_position,
   output logic [tce_pkg::CellWidth-1:0]         rsp_cell_value,
   input  wire logic                             csr_wr_en,
   input  wire logic [tce_pkg::AttrWidth-1:0]    csr_wr_data
);

   tce_pkg::entry_type front_entry;
   tce_pkg::entry_type head;
   logic               q_full, q_empty, q_pop;
   logic               busy_init;

   // no words taken while the store is being initialised
   assign req_full = q_full || busy_init;

   // classify and clamp
   tce_front #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_front (
      .command    (req_command),
      .char_code  (req_char_code),
      .target_row (req_target_row),
      .target_col (req_target_col),
      .entry      (front_entry)
   );

   // queue between front and back
   tce_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_push && !req_full),
      .push_entry (front_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head       (head),
      .empty      (q_empty)
   );

   // execution, screen store and result register
   tce_back #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .head                (head),
      .q_empty             (q_empty),
      .q_pop               (q_pop),
      .busy_init           (busy_init),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .rsp_empty           (rsp_empty),
      .rsp_pop             (rsp_pop),
      .rsp_cursor_row      (rsp_cursor_row),
      .rsp_cursor_col      (rsp_cursor_col),
      .rsp_cursor_position (rsp_cursor_position),
      .rsp_cell_value      (rsp_cell_value)
   );

endmodule

`default_nettype wire

// File: sv/tce_front.sv
`default_nettype none

module tce_front #(
   parameter int COLUMNS = tce_pkg::DefColumns,
   parameter int ROWS    = tce_pkg::DefRows
) (
   input  wire logic [tce_pkg::CmdWidth-1:0]    command,
   input  wire logic [tce_pkg::CharWidth-1:0]   char_code,
   input  wire logic [tce_pkg::TargetWidth-1:0] target_row,
   input  wire logic [tce_pkg::TargetWidth-1:0] target_col,
   output tce_pkg::entry_type                   entry
);

   localparam int TW = tce_pkg::TargetWidth;

   // decode the command, splitting newline out of put char
   always_comb begin
      case (command)
         tce_pkg::CmdPutChar: begin
            entry.op = (char_code == tce_pkg::CharNewline) ? tce_pkg::OpNewline
                                                             : tce_pkg::OpPutChar;
         end
         tce_pkg::CmdBackspace: entry.op = tce_pkg::OpBackspace;
         tce_pkg::CmdClear:     entry.op = tce_pkg::OpClear;
         tce_pkg::CmdSetCursor: entry.op = tce_pkg::OpSetCursor;
         tce_pkg::CmdReadCell:  entry.op = tce_pkg::OpReadCell;
         default:               entry.op = tce_pkg::OpNop;
      endcase

      // clamp targets to the last row and column
      entry.char_code = char_code;
      entry.row = (target_row >= TW'(ROWS)) ? TW'(ROWS - 1) : target_row;
      entry.col = (target_col >= TW'(COLUMNS)) ? TW'(COLUMNS - 1) : target_col;
   end

endmodule

`default_nettype wire

// File: sv/tce_queue.sv
`default_nettype none

module tce_queue (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  wire tce_pkg::entry_type push_entry,
   output logic               full,
   input  wire logic          pop,
   output tce_pkg::entry_type head,
   output logic               empty
);

   localparam int Depth      = tce_pkg::QueueDepth;
   localparam int PtrWidth   = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CountWidth = $clog2(Depth + 1);

   tce_pkg::entry_type slots_ff [Depth];

   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic                  do_push, do_pop;

   assign full  = (count_ff == CountWidth'(Depth));
   assign empty = (count_ff == '0);
   assign head  = slots_ff[rd_ptr_ff];

   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // slot storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

// File: sv/tce_back.sv
`default_nettype none

module tce_back #(
   parameter int COLUMNS = tce_pkg::DefColumns,
   parameter int ROWS    = tce_pkg::DefRows
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // queued words from the front
   input  wire tce_pkg::entry_type               head,
   input  wire logic                             q_empty,
   output logic                                  q_pop,
   output logic                                  busy_init,
   // attribute register write
   input  wire logic                             csr_wr_en,
   input  wire logic [tce_pkg::AttrWidth-1:0]    csr_wr_data,
   // result register
   output logic                                  rsp_empty,
   input  wire logic                             rsp_pop,
   output logic [tce_pkg::RowOutWidth-1:0]       rsp_cursor_row,
   output logic [tce_pkg::ColOutWidth-1:0]       rsp_cursor_col,
   output logic [tce_pkg::PosOutWidth-1:0]       rsp_cursor_position,
   output logic [tce_pkg::CellWidth-1:0]         rsp_cell_value
);

   localparam int RW    = $clog2(ROWS);
   localparam int CW    = $clog2(COLUMNS);
   localparam int AW    = RW + CW;
   localparam int Depth = ROWS * (2 ** CW);
   localparam int CellW = tce_pkg::CellWidth;

   localparam logic [CellW-1:0] ResetCell = {tce_pkg::ResetAttribute, tce_pkg::CharSpace};

   typedef enum logic [1:0] {
      StInit,
      StIdle,
      StFill,
      StRead
   } state_type;

   state_type state_ff, state_in;

   logic [RW-1:0]    row_ff, row_in;
   logic [CW-1:0]    col_ff, col_in;
   logic [RW-1:0]    top_ff, top_in;
   logic [tce_pkg::AttrWidth-1:0] attr_ff;
   logic [AW-1:0]    fill_addr_ff, fill_addr_in;
   logic [AW-1:0]    fill_end_ff, fill_end_in;
   logic [CellW-1:0] fill_data_ff, fill_data_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [RW-1:0]    rsp_row_ff, rsp_row_in;
   logic [CW-1:0]    rsp_col_ff, rsp_col_in;
   logic [AW-1:0]    rsp_pos_ff, rsp_pos_in;
   logic [CellW-1:0] rsp_cell_ff, rsp_cell_in;

   // screen store and its port controls
   logic [CellW-1:0] screen_ff [Depth];
   logic [CellW-1:0] rd_data_ff;
   logic             mem_we;
   logic [AW-1:0]    mem_waddr;
   logic [CellW-1:0] mem_wdata;
   logic [AW-1:0]    mem_raddr;

   logic             take;
   logic             at_last_col, at_last_row;
   logic [RW-1:0]    top_inc;
   logic [RW-1:0]    cur_phys, prev_phys, read_phys;
   logic [CellW-1:0] blank_cell;

   // logical row to physical row through the scroll offset
   function automatic logic [RW-1:0] phys_row(input logic [RW-1:0] r, input logic [RW-1:0] t);
      logic [RW:0] s;
      s = {1'b0, r} + {1'b0, t};
      if (s >= (RW+1)'(ROWS)) begin
         s = s - (RW+1)'(ROWS);
      end
      return s[RW-1:0];
   endfunction

   assign take = (state_ff == StIdle) && !q_empty && (!rsp_valid_ff || rsp_pop);
   assign q_pop = take;
   assign busy_init = (state_ff == StInit);

   assign at_last_col = (col_ff == CW'(COLUMNS - 1));
   assign at_last_row = (row_ff == RW'(ROWS - 1));
   assign top_inc     = (top_ff == RW'(ROWS - 1)) ? '0 : top_ff + 1'b1;
   assign cur_phys    = phys_row(row_ff, top_ff);
   assign prev_phys   = phys_row(row_ff - 1'b1, top_ff);
   assign read_phys   = phys_row(RW'(head.row), top_ff);
   assign blank_cell  = {attr_ff, tce_pkg::CharSpace};
   assign mem_raddr   = {read_phys, CW'(head.col)};

   // sequencer: executes one queued word and sweeps for reset init, scroll and clear
   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      top_in       = top_ff;
      fill_addr_in = fill_addr_ff;
      fill_end_in  = fill_end_ff;
      fill_data_in = fill_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_pop;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_cell_in  = rsp_cell_ff;
      mem_we       = 1'b0;
      mem_waddr    = fill_addr_ff;
      mem_wdata    = fill_data_ff;

      case (state_ff)
         StInit, StFill: begin
            mem_we = 1'b1;
            if (fill_addr_ff == fill_end_ff) begin
               state_in = StIdle;
            end else begin
               fill_addr_in = fill_addr_ff + 1'b1;
            end
         end
         StIdle: begin
            if (take) begin
               case (head.op)
                  tce_pkg::OpPutChar, tce_pkg::OpNewline: begin
                     if (head.op == tce_pkg::OpPutChar) begin
                        mem_we    = 1'b1;
                        mem_waddr = {cur_phys, col_ff};
                        mem_wdata = {attr_ff, head.char_code};
                        col_in    = col_ff + 1'b1;
                     end
                     if (head.op == tce_pkg::OpNewline || at_last_col) begin
                        col_in = '0;
                        if (at_last_row) begin
                           // scroll: old top row becomes the blank bottom row
                           top_in       = top_inc;
                           fill_addr_in = {top_ff, CW'(0)};
                           fill_end_in  = {top_ff, CW'(COLUMNS - 1)};
                           fill_data_in = blank_cell;
                           state_in     = StFill;
                        end else begin
                           row_in = row_ff + 1'b1;
                        end
                     end
                  end
                  tce_pkg::OpBackspace: begin
                     if (col_ff != '0) begin
                        col_in    = col_ff - 1'b1;
                        mem_we    = 1'b1;
                        mem_waddr = {cur_phys, col_ff - 1'b1};
                        mem_wdata = blank_cell;
                     end else if (row_ff != '0) begin
                        row_in    = row_ff - 1'b1;
                        col_in    = CW'(COLUMNS - 1);
                        mem_we    = 1'b1;
                        mem_waddr = {prev_phys, CW'(COLUMNS - 1)};
                        mem_wdata = blank_cell;
                     end
                  end
                  tce_pkg::OpClear: begin
                     row_in       = '0;
                     col_in       = '0;
                     top_in       = '0;
                     fill_addr_in = '0;
                     fill_end_in  = AW'(Depth - 1);
                     fill_data_in = blank_cell;
                     state_in     = StFill;
                  end
                  tce_pkg::OpSetCursor: begin
                     row_in = RW'(head.row);
                     col_in = CW'(head.col);
                  end
                  tce_pkg::OpReadCell: begin
                     state_in = StRead;
                  end
                  default: begin
                  end
               endcase
               // every word but read cell reports at once
               if (head.op != tce_pkg::OpReadCell) begin
                  rsp_valid_in = 1'b1;
                  rsp_row_in   = row_in;
                  rsp_col_in   = col_in;
                  rsp_pos_in   = AW'({{CW{1'b0}}, row_in} * AW'(COLUMNS)) + AW'(col_in);
                  rsp_cell_in  = '0;
               end
            end
         end
         StRead: begin
            // slot was freed when the word was taken
            rsp_valid_in = 1'b1;
            rsp_row_in   = row_ff;
            rsp_col_in   = col_ff;
            rsp_pos_in   = AW'({{CW{1'b0}}, row_ff} * AW'(COLUMNS)) + AW'(col_ff);
            rsp_cell_in  = rd_data_ff;
            state_in     = StIdle;
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StInit;
         row_ff       <= '0;
         col_ff       <= '0;
         top_ff       <= '0;
         attr_ff      <= tce_pkg::ResetAttribute;
         fill_addr_ff <= '0;
         fill_end_ff  <= AW'(Depth - 1);
         fill_data_ff <= ResetCell;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         top_ff       <= top_in;
         fill_addr_ff <= fill_addr_in;
         fill_end_ff  <= fill_end_in;
         fill_data_ff <= fill_data_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_row_ff   <= rsp_row_in;
         rsp_col_ff   <= rsp_col_in;
         rsp_pos_ff   <= rsp_pos_in;
         rsp_cell_ff  <= rsp_cell_in;
         if (csr_wr_en) begin
            attr_ff <= csr_wr_data;
         end
      end
   end

   // screen store: one write and one registered read a cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         screen_ff[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= screen_ff[mem_raddr];
   end

   assign rsp_empty           = !rsp_valid_ff;
   assign rsp_cursor_row      = tce_pkg::RowOutWidth'(rsp_row_ff);
   assign rsp_cursor_col      = tce_pkg::ColOutWidth'(rsp_col_ff);
   assign rsp_cursor_position = tce_pkg::PosOutWidth'(rsp_pos_ff);
   assign rsp_cell_value      = rsp_cell_ff;

endmodule

`default_nettype wire
